>>> hw/rtl/rgbblit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rgbblit_pkg;

    // Configuration port geometry.
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_BITS-1:0] REG_POS_X       = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_POS_Y       = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_SIZE  = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CLIP_LEFT   = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CLIP_TOP    = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CLIP_RIGHT  = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CLIP_BOTTOM = 3'd6;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ALPHA_MODE  = 3'd7;

    // Stream geometry.
    localparam int BYTE_BITS   = 8;
    localparam int COLOR_BITS  = 24;
    localparam int INDEX_BITS  = 16;
    localparam int COUNT_BITS  = 5;
    localparam int OUT_DATA_BITS = 56;
    localparam int OUT_USER_BITS = 2;

    // Reset values of the configuration registers.
    localparam logic [31:0] IMAGE_SIZE_RESET = 32'h0001_0001;
    localparam logic [15:0] CLIP_MAX_RESET   = 16'h7FFF;

    // One result beat as held in the output buffer.
    typedef struct packed {
        logic [15:0]           x;
        logic [15:0]           y;
        logic [COLOR_BITS-1:0] rgb;
        logic                  wr;
        logic                  done;
        logic                  last;
    } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/rgb888_image_blit_alpha1_unpack.sv
`timescale 1ns / 1ps
`default_nettype none

// RGB888 image blit unpacker. Image bytes enter on the s_ side, one per beat, and
// the block emits clipped pixel writes (screen x, y, color) on the m_ side. In plain
// mode three bytes form a pixel; in alpha mode each pixel is an alpha bit optionally
// followed by 24 color bits, LSB first across the whole image. A beat is sent for
// every opaque pixel inside the clip rectangle and always for the final pixel
// (image_done set), after which the rest of that byte is dropped and the next byte
// starts a new image. The block takes one byte per clock unless back-pressure stalls
// it; all eight bits of a byte are resolved in one pass between the input register
// and the event register, so the column/row walker is the longest path. A byte yields
// at most two result beats, sent one per clock while m_tready is high; a byte passes
// the input register, the event register and the output buffer in that order.
// Configuration may only be written while the block is idle.
module rgb888_image_blit_alpha1_unpack #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // Input stream: tdata = stream_byte[7:0].
    input  wire logic [rgbblit_pkg::BYTE_BITS-1:0]      s_tdata,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // Result stream: tdata = pixel_x[15:0], pixel_y[31:16], pixel_rgb[55:32].
    output logic [rgbblit_pkg::OUT_DATA_BITS-1:0]       m_tdata,
    // tuser = write_pixel[0], image_done[1].
    output logic [rgbblit_pkg::OUT_USER_BITS-1:0]       m_tuser,
    output logic                                        m_tlast,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // Configuration write port.
    input  wire logic                                   cfg_we,
    input  wire logic [rgbblit_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  wire logic [rgbblit_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

    import rgbblit_pkg::*;

    // Width used for screen arithmetic and clip compares.
    localparam int SUMW = (COORD_BITS > 16) ? COORD_BITS : 16;

    // Configuration registers.
    logic signed [15:0] pos_x_reg, pos_y_reg;
    logic        [31:0] image_size_reg;
    logic signed [15:0] clip_left_reg, clip_top_reg, clip_right_reg, clip_bottom_reg;
    logic               alpha_mode_reg;

    // Unpacker state.
    logic                  exp_reg, exp_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [COLOR_BITS-1:0] bits_reg, bits_next;
    logic [INDEX_BITS-1:0] col_reg, col_next;
    logic [INDEX_BITS-1:0] row_reg, row_next;

    // Input register.
    logic                 v0_reg;
    logic [BYTE_BITS-1:0] byte0_reg;

    // Event register: opaque finish (a) and transparent final (b).
    logic                  v1_reg;
    logic                  a_hit_reg, a_hit_next;
    logic [INDEX_BITS-1:0] a_col_reg, a_col_next, a_row_reg, a_row_next;
    logic [COLOR_BITS-1:0] a_rgb_reg, a_rgb_next;
    logic                  a_fin_reg, a_fin_next;
    logic                  b_hit_reg, b_hit_next;
    logic [INDEX_BITS-1:0] b_col_reg, b_col_next, b_row_reg, b_row_next;

    // Output buffer: slot a goes out before slot b.
    logic        ova_reg, ovb_reg;
    res_t        resa_reg, resa_next;
    logic [15:0] bx_reg, by_reg;

    // Handshake controls.
    logic s2_free, s1_adv, s1_ready, s2_load, take_a, take_b, proc_en;

    // Image geometry.
    logic [INDEX_BITS-1:0] img_w, img_h, w_m1, h_m1;
    logic                  img_empty;

    // Bit walker working variables.
    logic                  st_exp, st_stop, fin, fin_opaque, row_end, at_final;
    logic [COUNT_BITS-1:0] st_cnt;
    logic [COLOR_BITS-1:0] st_bits;
    logic [INDEX_BITS-1:0] st_col, st_row;

    // Coordinates and clip for the event register contents.
    logic signed [SUMW-1:0] ax, ay, bx, by;
    logic                   a_inside, a_emit;

    function automatic logic signed [SUMW-1:0] screen_coord(
        input logic signed [15:0]           base,
        input logic        [INDEX_BITS-1:0] idx
    );
        logic [SUMW-1:0] sum;
        sum = SUMW'(base) + SUMW'(idx);
        return SUMW'($signed(sum[COORD_BITS-1:0]));
    endfunction

    assign img_w     = image_size_reg[15:0];
    assign img_h     = image_size_reg[31:16];
    assign w_m1      = img_w - 16'd1;
    assign h_m1      = img_h - 16'd1;
    assign img_empty = (img_w == '0) || (img_h == '0);

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            image_size_reg  <= IMAGE_SIZE_RESET;
            clip_left_reg   <= '0;
            clip_top_reg    <= '0;
            clip_right_reg  <= CLIP_MAX_RESET;
            clip_bottom_reg <= CLIP_MAX_RESET;
            alpha_mode_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_POS_X:       pos_x_reg       <= cfg_wdata[15:0];
                REG_POS_Y:       pos_y_reg       <= cfg_wdata[15:0];
                REG_IMAGE_SIZE:  image_size_reg  <= cfg_wdata[31:0];
                REG_CLIP_LEFT:   clip_left_reg   <= cfg_wdata[15:0];
                REG_CLIP_TOP:    clip_top_reg    <= cfg_wdata[15:0];
                REG_CLIP_RIGHT:  clip_right_reg  <= cfg_wdata[15:0];
                REG_CLIP_BOTTOM: clip_bottom_reg <= cfg_wdata[15:0];
                REG_ALPHA_MODE:  alpha_mode_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control.
    assign take_a   = m_tready && ova_reg;
    assign take_b   = m_tready && !ova_reg && ovb_reg;
    assign s2_free  = (!ova_reg && !ovb_reg) || (m_tready && (ova_reg ^ ovb_reg));
    assign s1_adv   = v1_reg && (s2_free || !(a_emit || b_hit_reg));
    assign s2_load  = s1_adv && s2_free;
    assign s1_ready = !v1_reg || s1_adv;
    assign s_tready = !v0_reg || s1_ready;
    assign proc_en  = v0_reg && s1_ready && !img_empty;

    // Walk the eight bits of the held byte. The color bits shift in from the top,
    // so after 24 color bits the first one sits in bit 0.
    always_comb begin
        st_exp     = exp_reg;
        st_cnt     = cnt_reg;
        st_bits    = bits_reg;
        st_col     = col_reg;
        st_row     = row_reg;
        st_stop    = 1'b0;
        fin        = 1'b0;
        fin_opaque = 1'b0;
        row_end    = 1'b0;
        at_final   = 1'b0;
        a_hit_next = 1'b0;
        a_col_next = col_reg;
        a_row_next = row_reg;
        a_rgb_next = bits_reg;
        a_fin_next = 1'b0;
        b_hit_next = 1'b0;
        b_col_next = col_reg;
        b_row_next = row_reg;
        for (int i = 0; i < BYTE_BITS; i++) begin
            fin        = 1'b0;
            fin_opaque = 1'b0;
            if (!st_stop) begin
                if (alpha_mode_reg && !st_exp) begin
                    if (byte0_reg[i]) begin
                        st_exp = 1'b1;
                        st_cnt = '0;
                    end else begin
                        fin = 1'b1;
                    end
                end else begin
                    st_bits = {byte0_reg[i], st_bits[COLOR_BITS-1:1]};
                    if (st_cnt == COUNT_BITS'(COLOR_BITS - 1)) begin
                        st_cnt     = '0;
                        st_exp     = 1'b0;
                        fin        = 1'b1;
                        fin_opaque = 1'b1;
                    end else begin
                        st_cnt = st_cnt + COUNT_BITS'(1);
                    end
                end
            end
            row_end  = (st_col >= w_m1);
            at_final = row_end && (st_row >= h_m1);
            if (fin) begin
                if (fin_opaque) begin
                    a_hit_next = 1'b1;
                    a_col_next = st_col;
                    a_row_next = st_row;
                    a_rgb_next = st_bits;
                    a_fin_next = at_final;
                end else if (at_final) begin
                    b_hit_next = 1'b1;
                    b_col_next = st_col;
                    b_row_next = st_row;
                end
                // Final pixel rearms; otherwise step the column or wrap the row.
                if (at_final) begin
                    st_cnt  = '0;
                    st_exp  = 1'b0;
                    st_col  = '0;
                    st_row  = '0;
                    st_stop = 1'b1;
                end else if (row_end) begin
                    st_col = '0;
                    st_row = st_row + INDEX_BITS'(1);
                end else begin
                    st_col = st_col + INDEX_BITS'(1);
                end
            end
        end
        exp_next  = st_exp;
        cnt_next  = st_cnt;
        bits_next = st_bits;
        col_next  = st_col;
        row_next  = st_row;
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (s_tready) begin
            v0_reg <= s_tvalid;
        end
        if (s_tready) begin
            byte0_reg <= s_tdata;
        end
    end

    // Unpacker state and event register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_reg <= 1'b0;
            cnt_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
            v1_reg  <= 1'b0;
        end else begin
            if (proc_en) begin
                exp_reg <= exp_next;
                cnt_reg <= cnt_next;
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s1_ready) begin
                v1_reg <= v0_reg;
            end
        end
        if (proc_en) begin
            bits_reg <= bits_next;
        end
        if (s1_ready) begin
            a_hit_reg <= a_hit_next && !img_empty;
            a_col_reg <= a_col_next;
            a_row_reg <= a_row_next;
            a_rgb_reg <= a_rgb_next;
            a_fin_reg <= a_fin_next;
            b_hit_reg <= b_hit_next && !img_empty;
            b_col_reg <= b_col_next;
            b_row_reg <= b_row_next;
        end
    end

    // Screen coordinates and clip test of the held events.
    always_comb begin
        ax       = screen_coord(pos_x_reg, a_col_reg);
        ay       = screen_coord(pos_y_reg, a_row_reg);
        bx       = screen_coord(pos_x_reg, b_col_reg);
        by       = screen_coord(pos_y_reg, b_row_reg);
        a_inside = (ax >= SUMW'(clip_left_reg)) && (ax <= SUMW'(clip_right_reg)) &&
                   (ay >= SUMW'(clip_top_reg))  && (ay <= SUMW'(clip_bottom_reg));
        a_emit   = a_hit_reg && (a_inside || a_fin_reg);
        resa_next.x    = ax[15:0];
        resa_next.y    = ay[15:0];
        resa_next.rgb  = a_inside ? a_rgb_reg : '0;
        resa_next.wr   = a_inside;
        resa_next.done = a_fin_reg;
        resa_next.last = !b_hit_reg;
    end

    // Output buffer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ova_reg <= 1'b0;
            ovb_reg <= 1'b0;
        end else if (s2_load) begin
            ova_reg <= a_emit;
            ovb_reg <= b_hit_reg;
        end else begin
            if (take_a) begin
                ova_reg <= 1'b0;
            end
            if (take_b) begin
                ovb_reg <= 1'b0;
            end
        end
        if (s2_load) begin
            resa_reg <= resa_next;
            bx_reg   <= bx[15:0];
            by_reg   <= by[15:0];
        end
    end

    // Result port: slot a first, then the final transparent pixel in slot b.
    assign m_tvalid = ova_reg || ovb_reg;
    always_comb begin
        if (ova_reg) begin
            m_tdata = {resa_reg.rgb, resa_reg.y, resa_reg.x};
            m_tuser = {resa_reg.done, resa_reg.wr};
            m_tlast = resa_reg.last;
        end else begin
            m_tdata = {{COLOR_BITS{1'b0}}, by_reg, bx_reg};
            m_tuser = {1'b1, 1'b0};
            m_tlast = 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> bench/rgb888_image_blit_alpha1_unpack_tb.sv
`timescale 1ns / 1ps

import rgbblit_pkg::*;

// Tracks the blitter's walk over the image and holds the pixel beats it must send.
class blit_scoreboard;
    // Shadow copies of the configuration registers.
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [31:0] img_size;
    logic [15:0] clip_l;
    logic [15:0] clip_t;
    logic [15:0] clip_r;
    logic [15:0] clip_b;
    bit          alpha_on;

    // Unpacker state.
    logic [31:0] color_acc;
    int          color_cnt;
    bit          want_color;
    logic [15:0] col;
    logic [15:0] row;

    res_t expected_q[$];
    res_t byte_out[$];

    int n_used   = 0;
    int n_beats  = 0;
    int n_writes = 0;
    int n_images = 0;
    int n_bad    = 0;
    int n_shown  = 0;

    function new();
        pos_x    = '0;
        pos_y    = '0;
        img_size = IMAGE_SIZE_RESET;
        clip_l   = '0;
        clip_t   = '0;
        clip_r   = CLIP_MAX_RESET;
        clip_b   = CLIP_MAX_RESET;
        alpha_on = 1'b0;
        clear_walk();
    endfunction

    function void clear_walk();
        color_acc  = '0;
        color_cnt  = 0;
        want_color = 1'b0;
        col        = '0;
        row        = '0;
    endfunction

    function void set_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic [31:0] val);
        case (idx)
            REG_POS_X:       pos_x = val[15:0];
            REG_POS_Y:       pos_y = val[15:0];
            REG_IMAGE_SIZE:  img_size = val;
            REG_CLIP_LEFT:   clip_l = val[15:0];
            REG_CLIP_TOP:    clip_t = val[15:0];
            REG_CLIP_RIGHT:  clip_r = val[15:0];
            REG_CLIP_BOTTOM: clip_b = val[15:0];
            REG_ALPHA_MODE:  alpha_on = val[0];
            default: ;
        endcase
    endfunction

    // Closes the current pixel and advances the walker. Returns 1 on the image's last pixel.
    function bit end_pixel(input bit opaque, input logic [COLOR_BITS-1:0] rgb);
        logic signed [15:0] x;
        logic signed [15:0] y;
        int unsigned        w;
        int unsigned        h;
        bit                 in_clip;
        bit                 row_end;
        bit                 last_px;
        bit                 wr;
        res_t               r;
        w = img_size[15:0];
        h = img_size[31:16];
        x = pos_x + col;
        y = pos_y + row;
        in_clip = x >= $signed(clip_l) && x <= $signed(clip_r) &&
                  y >= $signed(clip_t) && y <= $signed(clip_b);
        row_end = col >= w - 1;
        last_px = row_end && (row >= h - 1);
        wr = opaque && in_clip;
        if (wr || last_px) begin
            r.x    = x;
            r.y    = y;
            r.rgb  = wr ? rgb : '0;
            r.wr   = wr;
            r.done = last_px;
            r.last = 1'b0;
            byte_out.push_back(r);
        end
        if (last_px) begin
            clear_walk();
            return 1'b1;
        end
        if (row_end) begin
            col = '0;
            row = row + 16'd1;
        end else begin
            col = col + 16'd1;
        end
        return 1'b0;
    endfunction

    // Called for every accepted image byte.
    function void note_byte(input logic [7:0] value);
        int                    i;
        bit                    finished;
        logic [COLOR_BITS-1:0] rgb;
        res_t                  r;
        if (img_size[15:0] == 16'd0 || img_size[31:16] == 16'd0) begin
            return;
        end
        n_used++;
        byte_out.delete();
        for (i = 0; i < 8; i++) begin
            finished = 1'b0;
            if (alpha_on && !want_color) begin
                if (value[i]) begin
                    want_color = 1'b1;
                    color_acc  = '0;
                    color_cnt  = 0;
                end else begin
                    finished = end_pixel(1'b0, '0);
                end
            end else begin
                color_acc[color_cnt] = value[i];
                color_cnt++;
                if (color_cnt >= COLOR_BITS) begin
                    rgb        = color_acc[COLOR_BITS-1:0];
                    color_acc  = '0;
                    color_cnt  = 0;
                    want_color = 1'b0;
                    finished   = end_pixel(1'b1, rgb);
                end
            end
            if (finished) begin
                break;
            end
        end
        // The last beat caused by this byte carries tlast.
        if (byte_out.size() != 0) begin
            r = byte_out.pop_back();
            r.last = 1'b1;
            byte_out.push_back(r);
        end
        foreach (byte_out[k]) begin
            expected_q.push_back(byte_out[k]);
        end
    endfunction

    // Called for every accepted result beat.
    function void check_beat(input logic [OUT_DATA_BITS-1:0] data,
                             input logic [OUT_USER_BITS-1:0] user, input logic last_in);
        res_t got;
        res_t want;
        got.x    = data[15:0];
        got.y    = data[31:16];
        got.rgb  = data[55:32];
        got.wr   = user[0];
        got.done = user[1];
        got.last = last_in;
        n_beats++;
        if (got.wr) n_writes++;
        if (got.done) n_images++;
        if (expected_q.size() == 0) begin
            n_bad++;
            if (n_shown < 10) begin
                n_shown++;
                $display("%0t: unexpected pixel beat x=%0d y=%0d rgb=%06h wr=%0b done=%0b last=%0b",
                         $time, $signed(got.x), $signed(got.y), got.rgb, got.wr, got.done,
                         got.last);
            end
            return;
        end
        want = expected_q.pop_front();
        if (got !== want) begin
            n_bad++;
            if (n_shown < 10) begin
                n_shown++;
                $display("%0t: pixel beat mismatch", $time);
                $display("    expected x=%0d y=%0d rgb=%06h wr=%0b done=%0b last=%0b",
                         $signed(want.x), $signed(want.y), want.rgb, want.wr, want.done,
                         want.last);
                $display("    actual   x=%0d y=%0d rgb=%06h wr=%0b done=%0b last=%0b",
                         $signed(got.x), $signed(got.y), got.rgb, got.wr, got.done,
                         got.last);
            end
        end
    endfunction
endclass

module rgb888_image_blit_alpha1_unpack_tb;

    localparam int TOTAL_ITEMS = 1850;
    localparam int SETTLE_CYCLES = 10;
    localparam int STALL_LIMIT = 1000;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic [BYTE_BITS-1:0]     s_tdata = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic [OUT_USER_BITS-1:0] m_tuser;
    logic                     m_tlast;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    blit_scoreboard sb;
    bit             steady = 1'b0;
    int             ready_hold = 0;
    int             quiet_cycles = 0;
    int             n_settings = 0;
    int             leftover;

    rgb888_image_blit_alpha1_unpack uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // Idle stretch length: mostly none, some short, a few long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 16'h7FFC + 16'($urandom_range(0, 3));
            1: return 16'h8000 + 16'($urandom_range(0, 3));
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 40)) - 16'd20;
        endcase
    endfunction

    function automatic void pick_clip(input logic [15:0] base, output logic [15:0] lo,
                                      output logic [15:0] hi);
        case ($urandom_range(0, 7))
            0: begin
                lo = 16'h8000;
                hi = 16'h7FFF;
            end
            1: begin
                // Empty window: left edge beyond right edge.
                lo = base + 16'd3;
                hi = base;
            end
            2: begin
                lo = 16'($urandom);
                hi = 16'($urandom);
            end
            default: begin
                lo = base + 16'($urandom_range(0, 6)) - 16'd2;
                hi = lo + 16'($urandom_range(0, 6));
            end
        endcase
    endfunction

    // Result side: random back-pressure, sometimes none at all.
    always @(negedge aclk) begin
        int n;
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_tready <= 1'b0;
        end else begin
            n = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
            if (n == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                ready_hold <= n - 1;
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_beat(m_tdata, m_tuser, m_tlast);
        end
    end

    // Watchdog on cycles without any beat or register write.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired with %0d pixel beats outstanding.", sb.expected_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Drives one image byte, with a random gap in front of it.
    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = idle_len();
        cfg_we <= 1'b0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'($urandom);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(value);
        @(negedge aclk);
    endtask

    // Starts a register write; cfg_we is lowered by the next stream or drain task.
    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        sb.set_reg(idx, val);
        @(negedge aclk);
    endtask

    // Waits until every pixel beat is out, then lets the pipeline empty.
    task automatic drain_and_pause();
        s_tvalid <= 1'b0;
        cfg_we <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Encodes one image for the current mode and sends it, optionally cut short.
    task automatic send_image(input int w, input int h, input bit cut);
        bit         bits[$];
        bit         opaque;
        int         density;
        int         nbytes;
        int         keep;
        int         i;
        int         k;
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0: density = 0;
            1: density = 100;
            2: density = 50;
            default: density = $urandom_range(0, 100);
        endcase
        for (i = 0; i < w * h; i++) begin
            opaque = !sb.alpha_on || ($urandom_range(0, 99) < density);
            if (sb.alpha_on) bits.push_back(opaque);
            if (opaque) begin
                for (k = 0; k < COLOR_BITS; k++) bits.push_back(1'($urandom));
            end
        end
        nbytes = (bits.size() + 7) / 8;
        keep = cut ? $urandom_range(1, nbytes) : nbytes;
        // Bits past the end of the image are random filler.
        for (i = 0; i < keep; i++) begin
            b = 8'($urandom);
            for (k = 0; k < 8; k++) begin
                if (i * 8 + k < bits.size()) b[k] = bits[i * 8 + k];
            end
            send_byte(b);
        end
    endtask

    // One random setting followed by images, noise or a cut-off image.
    task automatic random_phase();
        int          sel;
        int          kind;
        int          w;
        int          h;
        logic [31:0] size_val;
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] cl;
        logic [15:0] ct;
        logic [15:0] cr;
        logic [15:0] cb;
        drain_and_pause();
        steady = ($urandom_range(0, 4) == 0);
        n_settings++;
        px = rand_coord();
        py = rand_coord();
        pick_clip(px, cl, cr);
        pick_clip(py, ct, cb);
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 4);
        sel = $urandom_range(0, 15);
        if (sel == 2) begin
            w = $urandom_range(7, 40);
            h = 1;
        end else if (sel == 3) begin
            w = 1;
            h = $urandom_range(5, 12);
        end
        if (sel == 0) begin
            size_val = 32'hFFFF_FFFF;
        end else if (sel == 1) begin
            size_val = $urandom_range(0, 1) ? {16'($urandom_range(0, 5)), 16'h0000}
                                            : {16'h0000, 16'($urandom_range(0, 5))};
        end else begin
            size_val = {16'(h), 16'(w)};
        end
        // Upper bits of the 16-bit registers carry junk that must be ignored.
        write_reg(REG_POS_X, {16'($urandom), px});
        write_reg(REG_POS_Y, {16'($urandom), py});
        write_reg(REG_IMAGE_SIZE, size_val);
        write_reg(REG_CLIP_LEFT, {16'($urandom), cl});
        write_reg(REG_CLIP_TOP, {16'($urandom), ct});
        write_reg(REG_CLIP_RIGHT, {16'($urandom), cr});
        write_reg(REG_CLIP_BOTTOM, {16'($urandom), cb});
        write_reg(REG_ALPHA_MODE, {31'($urandom), 1'($urandom)});
        if (sel <= 1) begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
        end else begin
            kind = $urandom_range(0, 19);
            if (kind < 14) begin
                repeat ($urandom_range(1, 3)) send_image(w, h, 1'b0);
            end else if (kind < 17) begin
                repeat ($urandom_range(1, 16)) send_byte(8'($urandom));
            end else begin
                send_image(w, h, 1'b1);
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: a 1x1 plain image at the origin.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);

        // Zero width, then zero height: every byte is dropped.
        drain_and_pause();
        write_reg(REG_IMAGE_SIZE, 32'h0000_0000);
        send_byte(8'hFF);
        send_byte(8'h00);
        drain_and_pause();
        write_reg(REG_IMAGE_SIZE, 32'h0000_0003);
        send_byte(8'hA5);

        // Largest image at the positive screen edge, so the second column wraps negative.
        drain_and_pause();
        write_reg(REG_POS_X, 32'h0000_7FFF);
        write_reg(REG_POS_Y, 32'h0000_8000);
        write_reg(REG_CLIP_LEFT, 32'h0000_8000);
        write_reg(REG_CLIP_TOP, 32'h0000_8000);
        write_reg(REG_CLIP_RIGHT, 32'h0000_7FFF);
        write_reg(REG_CLIP_BOTTOM, 32'h0000_7FFF);
        write_reg(REG_IMAGE_SIZE, 32'hFFFF_FFFF);
        repeat (3) send_byte(8'hFF);
        repeat (3) send_byte(8'h00);

        // Shrinking to 1x1 mid-image makes the next pixel the final one.
        drain_and_pause();
        write_reg(REG_IMAGE_SIZE, 32'h0001_0001);
        send_byte(8'h81);
        send_byte(8'h42);
        send_byte(8'h24);

        // Alpha bitstream, 3x1: an opaque white pixel, then a color left unfinished.
        drain_and_pause();
        write_reg(REG_ALPHA_MODE, 32'h0000_0001);
        write_reg(REG_IMAGE_SIZE, 32'h0001_0003);
        repeat (4) send_byte(8'hFF);
        repeat (2) send_byte(8'h00);

        // Back to plain mode while a color is still being collected.
        drain_and_pause();
        write_reg(REG_ALPHA_MODE, 32'h0000_0000);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);

        while (sb.n_used < TOTAL_ITEMS) random_phase();

        drain_and_pause();
        repeat (2 * SETTLE_CYCLES) @(negedge aclk);
        leftover = sb.expected_q.size();
        if (leftover != 0) begin
            $display("%0d expected pixel beats never arrived.", leftover);
        end
        $display("Sent %0d image bytes over %0d random settings plus the directed cases.",
                 sb.n_used, n_settings);
        $display("Checked %0d pixel beats: %0d stored pixels, %0d finished images, %0d bad.",
                 sb.n_beats, sb.n_writes, sb.n_images, sb.n_bad);
        if (sb.n_bad == 0 && leftover == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
